// File: hw/rtl/three_stacks_one_memory_assert.svh
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef THREE_STACKS_ONE_MEMORY_ASSERT_SVH
`define THREE_STACKS_ONE_MEMORY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSOM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSOM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tsom_pkg.sv
package tsom_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 9;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // Stack id three addresses no stack.
  localparam logic [1:0] SID_NONE = 2'd3;
  localparam int unsigned NUM_STACKS = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET = 9'd256;
  localparam logic [WORD_W-1:0] NO_WORD   = '1;

  typedef struct packed {
    logic [1:0]               mode;
    logic [1:0]               stack_id;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic                     done_res;
    logic                     now_empty;
  } res_t;

  // Result bookkeeping held while the memory read completes.
  typedef struct packed {
    logic rd_sel;
    logic done;
    logic empty;
  } stage_t;

endpackage

// File: hw/rtl/tsom_if.sv
interface tsom_req_if;
  logic          valid;
  logic          ready;
  tsom_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsom_res_if;
  logic          valid;
  logic          ready;
  tsom_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tsom_ram.sv
module tsom_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/three_stacks_one_memory.sv
// Channel   Dir  Payload                             Accepted when
// in_req    in   mode, stack_id, push_value          valid && ready
// out_res   out  read_value, done_res, now_empty     valid && ready
// cfg       in   stack_capacity (9 bits)             cfg_we high
//
// One request per cycle unless out_res stalls; its result appears the cycle
// after acceptance. Fill counts live in flip-flops and are updated at
// acceptance, so the next request sees them at once; the word store is read
// or written in that cycle. Reset clears the counts and out_valid_r and sets
// the capacity to 256. A stalled result holds the memory output; a new
// request is taken if the output slot is empty or emptied in the same cycle.
`include "three_stacks_one_memory_assert.svh"

module three_stacks_one_memory #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tsom_req_if.sink                     in_req,
  tsom_res_if.source                   out_res,
  input  logic                         cfg_we,
  input  logic [tsom_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int unsigned STORE_WORDS = tsom_pkg::NUM_STACKS * STACK_DEPTH;
  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LW = (CW > tsom_pkg::CAP_W) ? CW : tsom_pkg::CAP_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
  localparam logic [AW-1:0] REGION  = AW'(STACK_DEPTH);

  logic [tsom_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]              counts_r [tsom_pkg::NUM_STACKS];
  logic                       out_valid_r;
  tsom_pkg::stage_t           stage_r, stage_nxt;

  logic                in_acc;
  logic                sid_ok;
  logic [CW-1:0]       cnt, cnt_nxt;
  logic [LW-1:0]       limit;
  logic                push_ok, read_ok;
  logic [AW-1:0]       base;
  logic [AW-1:0]       waddr, raddr;
  logic                ram_we, ram_re;
  logic [tsom_pkg::WORD_W-1:0] ram_q;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_acc       = in_req.valid && in_req.ready;
  assign sid_ok       = in_req.data.stack_id != tsom_pkg::SID_NONE;

  always_comb begin
    cnt = '0;
    if (sid_ok) begin
      cnt = counts_r[in_req.data.stack_id];
    end
  end

  // The capacity is clamped to the region size.
  assign limit = (LW'(cap_r) > DEPTH_L) ? DEPTH_L : LW'(cap_r);

  assign push_ok = sid_ok && (in_req.data.mode == tsom_pkg::MODE_PUSH) &&
                   (LW'(cnt) < limit);
  assign read_ok = sid_ok && ((in_req.data.mode == tsom_pkg::MODE_POP) ||
                              (in_req.data.mode == tsom_pkg::MODE_PEEK)) &&
                   (cnt != '0);

  always_comb begin
    cnt_nxt = cnt;
    if (push_ok) begin
      cnt_nxt = cnt + 1'b1;
    end else if (read_ok && (in_req.data.mode == tsom_pkg::MODE_POP)) begin
      cnt_nxt = cnt - 1'b1;
    end
  end

  assign base  = AW'(in_req.data.stack_id) * REGION;
  assign waddr = base + AW'(cnt);
  assign raddr = base + AW'(cnt) - AW'(1);

  assign ram_we = in_acc && push_ok;
  assign ram_re = in_acc && read_ok;

  tsom_ram #(
    .WIDTH (tsom_pkg::WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_req.data.push_value),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_comb begin
    stage_nxt.rd_sel = read_ok;
    stage_nxt.done   = push_ok || read_ok;
    stage_nxt.empty  = sid_ok && (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= tsom_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < tsom_pkg::NUM_STACKS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < tsom_pkg::NUM_STACKS; i++) begin
          if (sid_ok && (in_req.data.stack_id == 2'(i))) begin
            counts_r[i] <= cnt_nxt;
          end
        end
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data.read_value = stage_r.rd_sel ? ram_q : tsom_pkg::NO_WORD;
  assign out_res.data.done_res   = stage_r.done;
  assign out_res.data.now_empty  = stage_r.empty;

  `TSOM_ASSERT_NEXT(a_accept_gives_result, in_acc, out_valid_r,
                    "accepted request produced no result")
  `TSOM_ASSERT_SAME(a_no_write_past_limit, ram_we, sid_ok && (LW'(cnt) < limit),
                    "word store written beyond the stack limit")
  `TSOM_ASSERT_NEXT(a_no_stack_inert, in_acc && !sid_ok,
                    !stage_r.done && !stage_r.empty && !stage_r.rd_sel,
                    "request to no stack reported work")

endmodule
